// File: sv/srsw_pkg.sv
// Shared types, constants and control/status structs of the sender window.
package srsw_pkg;

  localparam int WINDOW_DEPTH = 16;
  localparam int IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);

  localparam int FUNC_W  = 2;
  localparam int TYPE_W  = 8;
  localparam int SEQ_W   = 32;
  localparam int AGE_W   = 16;
  localparam int LIMIT_W = 5;
  localparam int OUTST_W = 5;
  localparam int KIND_W  = 3;

  // Width that holds the count, the configured limit and the depth alike.
  localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [TYPE_W-1:0]  ACK_TYPE          = 8'd3;
  localparam logic [LIMIT_W-1:0] WINDOW_LIMIT_RST  = 5'd8;
  localparam logic [AGE_W-1:0]   TIMEOUT_TICKS_RST = 16'd500;
  localparam logic [AGE_W-1:0]   AGE_MAX           = 16'hFFFF;

  // Register select: bit 2 of the byte address.
  localparam logic REG_WINDOW_LIMIT  = 1'b0;
  localparam logic REG_TIMEOUT_TICKS = 1'b1;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_OFFER = 2'd0,
    FUNC_ACK   = 2'd1,
    FUNC_TICK  = 2'd2,
    FUNC_NOP   = 2'd3
  } func_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_SENT    = 3'd0,
    KIND_FULL    = 3'd1,
    KIND_CLEARED = 3'd2,
    KIND_IGNORED = 3'd3,
    KIND_RETX    = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_MATCH,
    ST_OFFER_FIN,
    ST_ACK_FIN,
    ST_AGE,
    ST_SELECT,
    ST_RETX
  } state_e;

  typedef struct packed {
    logic [LIMIT_W-1:0] window_limit;
    logic [AGE_W-1:0]   timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic  load;
    logic  match_step;
    logic  age_step;
    logic  sel_init;
    logic  sel_step;
    logic  offer_commit;
    logic  ack_commit;
    logic  retx_commit;
    logic  emit;
    kind_e kind;
  } cmd_t;

  typedef struct packed {
    func_e func;
    logic  full;
    logic  is_ack;
    logic  idx_last;
    logic  hit;
    logic  free;
    logic  best_found;
    logic  best_last;
  } status_t;

endpackage

// File: sv/srsw_cfg.sv
// APB-style configuration registers: window limit and timeout.
module srsw_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [srsw_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [srsw_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [srsw_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  output srsw_pkg::cfg_t                      cfg_o
);

  logic [srsw_pkg::LIMIT_W-1:0] window_limit_q, window_limit_d;
  logic [srsw_pkg::AGE_W-1:0]   timeout_ticks_q, timeout_ticks_d;
  logic                         wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    window_limit_d  = window_limit_q;
    timeout_ticks_d = timeout_ticks_q;
    if (wr_en) begin
      if (paddr[2] == srsw_pkg::REG_TIMEOUT_TICKS) begin
        timeout_ticks_d = pwdata[srsw_pkg::AGE_W-1:0];
      end else begin
        window_limit_d = pwdata[srsw_pkg::LIMIT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_limit_q  <= srsw_pkg::WINDOW_LIMIT_RST;
      timeout_ticks_q <= srsw_pkg::TIMEOUT_TICKS_RST;
    end else begin
      window_limit_q  <= window_limit_d;
      timeout_ticks_q <= timeout_ticks_d;
    end
  end

  always_comb begin
    if (paddr[2] == srsw_pkg::REG_TIMEOUT_TICKS) begin
      prdata = srsw_pkg::APB_DATA_W'(timeout_ticks_q);
    end else begin
      prdata = srsw_pkg::APB_DATA_W'(window_limit_q);
    end
  end

  assign cfg_o.window_limit  = window_limit_q;
  assign cfg_o.timeout_ticks = timeout_ticks_q;

endmodule

// File: sv/srsw_ctrl.sv
// Controller state machine that sequences the entry scans of the window.
module srsw_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  srsw_pkg::status_t status_i,
  output srsw_pkg::cmd_t    cmd_o
);

  srsw_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= srsw_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.kind = srsw_pkg::KIND_SENT;
    busy    = (state_q != srsw_pkg::ST_IDLE);

    unique case (state_q)
      srsw_pkg::ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = srsw_pkg::ST_DISPATCH;
        end
      end

      srsw_pkg::ST_DISPATCH: begin
        unique case (status_i.func)
          srsw_pkg::FUNC_OFFER: begin
            if (status_i.full) begin
              cmd_o.emit = 1'b1;
              cmd_o.kind = srsw_pkg::KIND_FULL;
              state_d    = srsw_pkg::ST_IDLE;
            end else begin
              state_d = srsw_pkg::ST_MATCH;
            end
          end
          srsw_pkg::FUNC_ACK: begin
            if (!status_i.is_ack) begin
              cmd_o.emit = 1'b1;
              cmd_o.kind = srsw_pkg::KIND_IGNORED;
              state_d    = srsw_pkg::ST_IDLE;
            end else begin
              state_d = srsw_pkg::ST_MATCH;
            end
          end
          srsw_pkg::FUNC_TICK: state_d = srsw_pkg::ST_AGE;
          srsw_pkg::FUNC_NOP:  state_d = srsw_pkg::ST_IDLE;
          default:             state_d = srsw_pkg::ST_IDLE;
        endcase
      end

      srsw_pkg::ST_MATCH: begin
        cmd_o.match_step = 1'b1;
        if (status_i.idx_last) begin
          state_d = (status_i.func == srsw_pkg::FUNC_OFFER) ? srsw_pkg::ST_OFFER_FIN
                                                            : srsw_pkg::ST_ACK_FIN;
        end
      end

      srsw_pkg::ST_OFFER_FIN: begin
        cmd_o.emit = 1'b1;
        if (status_i.hit || status_i.free) begin
          cmd_o.offer_commit = 1'b1;
          cmd_o.kind         = srsw_pkg::KIND_SENT;
        end else begin
          cmd_o.kind = srsw_pkg::KIND_FULL;
        end
        state_d = srsw_pkg::ST_IDLE;
      end

      srsw_pkg::ST_ACK_FIN: begin
        cmd_o.emit = 1'b1;
        if (status_i.hit) begin
          cmd_o.ack_commit = 1'b1;
          cmd_o.kind       = srsw_pkg::KIND_CLEARED;
        end else begin
          cmd_o.kind = srsw_pkg::KIND_IGNORED;
        end
        state_d = srsw_pkg::ST_IDLE;
      end

      srsw_pkg::ST_AGE: begin
        cmd_o.age_step = 1'b1;
        if (status_i.idx_last) begin
          cmd_o.sel_init = 1'b1;
          state_d        = srsw_pkg::ST_SELECT;
        end
      end

      srsw_pkg::ST_SELECT: begin
        cmd_o.sel_step = 1'b1;
        if (status_i.idx_last) begin
          state_d = srsw_pkg::ST_RETX;
        end
      end

      srsw_pkg::ST_RETX: begin
        if (!status_i.best_found) begin
          state_d = srsw_pkg::ST_IDLE;
        end else begin
          cmd_o.retx_commit = 1'b1;
          cmd_o.emit        = 1'b1;
          cmd_o.kind        = srsw_pkg::KIND_RETX;
          if (status_i.best_last) begin
            state_d = srsw_pkg::ST_IDLE;
          end else begin
            cmd_o.sel_init = 1'b1;
            state_d        = srsw_pkg::ST_SELECT;
          end
        end
      end

      default: state_d = srsw_pkg::ST_IDLE;
    endcase
  end

endmodule

// File: sv/srsw_datapath.sv
// Window datapath: entry storage, scan index, match/age/oldest-due logic, result register.
module srsw_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  srsw_pkg::cfg_t                  cfg_i,
  input  srsw_pkg::cmd_t                  cmd_i,
  output srsw_pkg::status_t               status_o,
  input  logic [srsw_pkg::FUNC_W-1:0]     func_i,
  input  logic [srsw_pkg::TYPE_W-1:0]     packet_type_i,
  input  logic [srsw_pkg::SEQ_W-1:0]      ack_seq_i,
  output logic                            result_valid_o,
  output logic [srsw_pkg::KIND_W-1:0]     kind_o,
  output logic [srsw_pkg::SEQ_W-1:0]      seq_o,
  output logic [srsw_pkg::OUTST_W-1:0]    outstanding_o,
  output logic                            last_o
);

  localparam int D     = srsw_pkg::WINDOW_DEPTH;
  localparam int IW    = srsw_pkg::IDX_W;
  localparam int CW    = srsw_pkg::CNT_W;
  localparam int MW    = srsw_pkg::CMP_W;
  localparam int SW    = srsw_pkg::SEQ_W;
  localparam int AW    = srsw_pkg::AGE_W;

  // Entry storage.
  logic [D-1:0]  valid_q;
  logic [SW-1:0] seq_mem [D];
  logic [AW-1:0] age_mem [D];
  logic [D-1:0]  due_q;

  logic [SW-1:0] last_seq_q;
  logic [CW-1:0] count_q, count_d;

  // Latched item.
  srsw_pkg::func_e      op_func_q;
  logic [srsw_pkg::TYPE_W-1:0] op_type_q;
  logic [SW-1:0]        op_seq_q;

  // Scan state.
  logic [IW-1:0] idx_q;
  logic          hit_q, free_q, best_found_q;
  logic [IW-1:0] hit_idx_q, free_idx_q, best_idx_q;
  logic [SW-1:0] best_dist_q, best_seq_q;

  // Result register.
  logic                         out_valid_q;
  srsw_pkg::kind_e              out_kind_q;
  logic [SW-1:0]                out_seq_q;
  logic [srsw_pkg::OUTST_W-1:0] out_cnt_q;
  logic                         out_last_q;

  logic          cur_valid;
  logic [SW-1:0] cur_seq;
  logic [AW-1:0] cur_age, age_inc;
  logic [SW-1:0] next_seq, target_seq, cur_dist;
  logic          idx_last, step;
  logic [IW-1:0] slot;
  logic [D-1:0]  best_oh;
  logic [MW-1:0] limit_eff, count_ext, count_d_ext;
  logic [SW-1:0] emit_seq;

  assign cur_valid  = valid_q[idx_q];
  assign cur_seq    = seq_mem[idx_q];
  assign cur_age    = age_mem[idx_q];
  assign age_inc    = (cur_age != srsw_pkg::AGE_MAX) ? cur_age + AW'(1) : cur_age;
  assign next_seq   = last_seq_q + SW'(1);
  assign target_seq = (op_func_q == srsw_pkg::FUNC_OFFER) ? next_seq : op_seq_q;
  assign cur_dist   = last_seq_q - cur_seq;
  assign idx_last   = (idx_q == IW'(D - 1));
  assign step       = cmd_i.match_step | cmd_i.age_step | cmd_i.sel_step;
  assign slot       = hit_q ? hit_idx_q : free_idx_q;
  assign best_oh    = D'(1) << best_idx_q;

  // A limit above the depth acts as the depth.
  assign limit_eff = (MW'(cfg_i.window_limit) > MW'(D)) ? MW'(D) : MW'(cfg_i.window_limit);
  assign count_ext = MW'(count_q);

  always_comb begin
    count_d = count_q;
    if (cmd_i.offer_commit && !hit_q) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.ack_commit) begin
      count_d = count_q - CW'(1);
    end
  end

  assign count_d_ext = MW'(count_d);

  always_comb begin
    unique case (cmd_i.kind)
      srsw_pkg::KIND_SENT:    emit_seq = next_seq;
      srsw_pkg::KIND_FULL:    emit_seq = '0;
      srsw_pkg::KIND_CLEARED: emit_seq = op_seq_q;
      srsw_pkg::KIND_IGNORED: emit_seq = op_seq_q;
      srsw_pkg::KIND_RETX:    emit_seq = best_seq_q;
      default:                emit_seq = '0;
    endcase
  end

  // Control state and valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      due_q        <= '0;
      last_seq_q   <= '0;
      count_q      <= '0;
      op_func_q    <= srsw_pkg::FUNC_NOP;
      idx_q        <= '0;
      hit_q        <= 1'b0;
      free_q       <= 1'b0;
      best_found_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      out_valid_q <= cmd_i.emit;
      count_q     <= count_d;

      if (cmd_i.load) begin
        op_func_q <= srsw_pkg::func_e'(func_i);
      end

      if (cmd_i.load || cmd_i.sel_init) begin
        idx_q <= '0;
      end else if (step) begin
        idx_q <= idx_last ? '0 : idx_q + IW'(1);
      end

      if (cmd_i.load) begin
        hit_q  <= 1'b0;
        free_q <= 1'b0;
      end else if (cmd_i.match_step) begin
        if (cur_valid && (cur_seq == target_seq) && !hit_q) begin
          hit_q <= 1'b1;
        end
        if (!cur_valid && !free_q) begin
          free_q <= 1'b1;
        end
      end

      if (cmd_i.sel_init) begin
        best_found_q <= 1'b0;
      end else if (cmd_i.sel_step && due_q[idx_q] &&
                   (!best_found_q || (cur_dist > best_dist_q))) begin
        best_found_q <= 1'b1;
      end

      if (cmd_i.age_step) begin
        due_q[idx_q] <= cur_valid && (age_inc >= cfg_i.timeout_ticks);
      end else if (cmd_i.retx_commit) begin
        due_q <= due_q & ~best_oh;
      end

      if (cmd_i.offer_commit) begin
        valid_q[slot] <= 1'b1;
        last_seq_q    <= next_seq;
      end else if (cmd_i.ack_commit) begin
        valid_q[hit_idx_q] <= 1'b0;
      end
    end
  end

  // Payload: entry storage, latched item, scan indexes and result fields.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_type_q <= packet_type_i;
      op_seq_q  <= ack_seq_i;
    end

    if (cmd_i.match_step) begin
      if (cur_valid && (cur_seq == target_seq) && !hit_q) begin
        hit_idx_q <= idx_q;
      end
      if (!cur_valid && !free_q) begin
        free_idx_q <= idx_q;
      end
    end

    if (cmd_i.sel_step && due_q[idx_q] && (!best_found_q || (cur_dist > best_dist_q))) begin
      best_idx_q  <= idx_q;
      best_dist_q <= cur_dist;
      best_seq_q  <= cur_seq;
    end

    if (cmd_i.offer_commit) begin
      seq_mem[slot] <= next_seq;
      age_mem[slot] <= '0;
    end else if (cmd_i.age_step && cur_valid) begin
      age_mem[idx_q] <= age_inc;
    end else if (cmd_i.retx_commit) begin
      age_mem[best_idx_q] <= '0;
    end

    if (cmd_i.emit) begin
      out_kind_q <= cmd_i.kind;
      out_seq_q  <= emit_seq;
      out_cnt_q  <= count_d_ext[srsw_pkg::OUTST_W-1:0];
      out_last_q <= (cmd_i.kind == srsw_pkg::KIND_RETX) ? status_o.best_last : 1'b1;
    end
  end

  assign status_o.func       = op_func_q;
  assign status_o.full       = (count_ext >= limit_eff);
  assign status_o.is_ack     = (op_type_q == srsw_pkg::ACK_TYPE);
  assign status_o.idx_last   = idx_last;
  assign status_o.hit        = hit_q;
  assign status_o.free       = free_q;
  assign status_o.best_found = best_found_q;
  assign status_o.best_last  = ~|(due_q & ~best_oh);

  assign result_valid_o = out_valid_q;
  assign kind_o         = out_kind_q;
  assign seq_o          = out_seq_q;
  assign outstanding_o  = out_cnt_q;
  assign last_o         = out_last_q;

endmodule

// File: sv/selective_repeat_sender_window.sv
// Top level of the selective-repeat sender window: config port, controller and datapath.
// An offer or a type-3 ack passes dispatch, a match scan of all 16 entries and a finish state;
// the result word is registered and appears as busy drops. A full window or a non-ack packet
// answers from dispatch. A tick ages all entries, then each retransmit takes an oldest-due
// select scan and a retransmit state; with nothing due, a select scan still runs. The result
// strobe lasts one cycle; the receiver cannot stall. Reset (rst_ni low, asynchronous) empties
// the window and restores the limit of 8 and the timeout of 500 ticks.
module selective_repeat_sender_window (
  input  logic                                clk_i,
  input  logic                                rst_ni,

  // Command channel: a word is taken when start is high and busy is low.
  input  logic                                start,
  output logic                                busy,
  input  logic [srsw_pkg::FUNC_W-1:0]         func_i,
  input  logic [srsw_pkg::TYPE_W-1:0]         packet_type_i,
  input  logic [srsw_pkg::SEQ_W-1:0]          ack_seq_i,

  // Result channel: one word per cycle in which result_valid_o is high.
  output logic                                result_valid_o,
  output logic [srsw_pkg::KIND_W-1:0]         kind_o,
  output logic [srsw_pkg::SEQ_W-1:0]          seq_o,
  output logic [srsw_pkg::OUTST_W-1:0]        outstanding_o,
  output logic                                last_o,

  // Configuration port.
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [srsw_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [srsw_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [srsw_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);

  // The window limit sits at byte address 0 and the timeout at byte address 4.
  srsw_pkg::cfg_t    cfg;
  srsw_pkg::cmd_t    cmd;
  srsw_pkg::status_t status;

  srsw_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // The controller walks the scan phases; it sees only the status struct and issues
  // one command struct per cycle.
  srsw_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .status_i (status),
    .cmd_o    (cmd)
  );

  // The datapath holds the entries and reads one of them per cycle at the scan index.
  // Retransmits leave in oldest-first order: each select scan keeps the due entry with
  // the greatest distance behind the last sequence number sent, the lowest slot on a tie.
  srsw_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .cmd_i          (cmd),
    .status_o       (status),
    .func_i         (func_i),
    .packet_type_i  (packet_type_i),
    .ack_seq_i      (ack_seq_i),
    .result_valid_o (result_valid_o),
    .kind_o         (kind_o),
    .seq_o          (seq_o),
    .outstanding_o  (outstanding_o),
    .last_o         (last_o)
  );

endmodule
